@@ sv/servo_joystick_light_tracker_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the servo joystick light tracker
// Concurrent checks sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERVO_JOYSTICK_LIGHT_TRACKER_UNIT_ASSERT_SVH
`define SERVO_JOYSTICK_LIGHT_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SJLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SJLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sjlt_pkg.sv @@
// ----------------------------------------------------------------------------
// sjlt_pkg
// Register map, reset values and shared helpers of the servo tracker.
// ----------------------------------------------------------------------------
package sjlt_pkg;

	// Configuration register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_POS_MIN        = 3'd0,
		REG_POS_MAX        = 3'd1,
		REG_STEP_SIZE      = 3'd2,
		REG_JOY_CENTER     = 3'd3,
		REG_JOY_THRESHOLD  = 3'd4,
		REG_LIGHT_TOL      = 3'd5,
		REG_DEBOUNCE_MS    = 3'd6,
		REG_HOME_POSITION  = 3'd7
	} reg_idx_t;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int TOL_W  = 10;

	// Reset values
	localparam logic [7:0]       POS_MIN_RST   = 8'd100;
	localparam logic [7:0]       POS_MAX_RST   = 8'd160;
	localparam logic [3:0]       STEP_RST      = 4'd2;
	localparam logic [7:0]       CENTER_RST    = 8'd128;
	localparam logic [7:0]       THRESH_RST    = 8'd120;
	localparam logic [TOL_W-1:0] TOL_RST       = 10'd50;
	localparam logic [15:0]      DEBOUNCE_RST  = 16'd300;
	localparam logic [7:0]       HOME_RST      = 8'd130;
	localparam logic [7:0]       POSITION_RST  = 8'd130;

	// True when more than db milliseconds have passed, modulo 2^32
	function automatic logic elapsed(logic [31:0] now, logic [31:0] last, logic [15:0] db);
		logic [31:0] delta;
		delta = now - last;
		return delta > {16'h0000, db};
	endfunction

endpackage

@@ sv/sjlt_if.sv @@
// ----------------------------------------------------------------------------
// sjlt_in_if / sjlt_out_if
// Valid/ready channels carrying control samples and servo results.
// ----------------------------------------------------------------------------
interface sjlt_in_if #(
	parameter int LIGHT_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [31:0]           now_ms;
	logic [7:0]            joystick_level;
	logic [LIGHT_BITS-1:0] left_light;
	logic [LIGHT_BITS-1:0] right_light;
	logic                  mode_press;
	logic                  save_press;
	logic                  recenter_press;

	modport source (
		output valid, now_ms, joystick_level, left_light, right_light,
		output mode_press, save_press, recenter_press,
		input ready
	);
	modport sink (
		input valid, now_ms, joystick_level, left_light, right_light,
		input mode_press, save_press, recenter_press,
		output ready
	);
endinterface

interface sjlt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] servo_position;
	logic       auto_mode;
	logic       save_request;

	modport source (
		output valid, servo_position, auto_mode, save_request,
		input ready
	);
	modport sink (
		input valid, servo_position, auto_mode, save_request,
		output ready
	);
endinterface

@@ sv/servo_joystick_light_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// servo_joystick_light_tracker_unit
// Servo position tracker driven by joystick, light sensors and buttons.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one control sample per request: timestamp, joystick level,
//          two light readings and the mode, save and recenter buttons.
//   out_ch returns one result per sample: servo position, auto mode flag and
//          a save request flag, in sample order.
//   APB    writes and reads the eight setup registers at byte address 4*i;
//          write them only while no sample is in flight.
// Path: each sample passes the input stage, then the output register, to out_ch.
// Throughput: one sample per cycle while out_ch is not held off; the position,
//   mode and debounce times are updated as each sample moves into the output
//   register, which keeps the rate at one.
// Reset: position 130, manual mode, all debounce times zero, registers at
//   their defaults, both pipeline stages empty.
// Stall: while out_ch is held off the result stays in the output register,
//   one more sample is taken into the input stage and then in_ch.ready drops.
// ----------------------------------------------------------------------------
`include "servo_joystick_light_tracker_unit_assert.svh"

module servo_joystick_light_tracker_unit #(
	parameter int LIGHT_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sjlt_in_if.sink                     in_ch,
	sjlt_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sjlt_pkg::ADDR_W-1:0] paddr,
	input  logic [sjlt_pkg::DATA_W-1:0] pwdata,
	output logic [sjlt_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int CMP_W = (LIGHT_BITS + 1 > sjlt_pkg::TOL_W) ?
		LIGHT_BITS + 1 : sjlt_pkg::TOL_W;

	// Configuration registers
	logic [7:0]                  pos_min_q, pos_max_q, center_q, thresh_q, home_q;
	logic [3:0]                  step_q;
	logic [sjlt_pkg::TOL_W-1:0]  tol_q;
	logic [15:0]                 debounce_q;

	// Tracker state
	logic [7:0]  pos_q;
	logic        auto_q;
	logic [31:0] last_move_q, last_mode_q, last_save_q;

	// Input stage
	logic                  valid_s1;
	logic [31:0]           now_s1;
	logic [7:0]            joy_s1;
	logic [LIGHT_BITS-1:0] left_s1, right_s1;
	logic                  mode_p_s1, save_p_s1, rec_p_s1;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_pos_q;
	logic       out_auto_q;
	logic       out_save_q;

	// Next-state values
	logic        adv_out;
	logic        mode_tgl, save_ok, auto_nx;
	logic [7:0]  pos_nx;
	logic [31:0] last_move_nx;
	logic signed [LIGHT_BITS:0] diff;
	logic [LIGHT_BITS:0]        mag;
	logic                       light_go;
	logic [8:0]  pos_up9, pos_dn9, min_plus9;
	logic signed [8:0] joy_off, thr_pos, thr_neg;
	logic        joy_up, joy_dn, move_ok;
	logic        cfg_wr;

	// Handshake: the input stage empties whenever the output register can load
	assign adv_out     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_out;

	assign out_ch.valid          = out_valid_q;
	assign out_ch.servo_position = out_pos_q;
	assign out_ch.auto_mode      = out_auto_q;
	assign out_ch.save_request   = out_save_q;

	// Button debounce and mode toggle
	assign mode_tgl = mode_p_s1 && sjlt_pkg::elapsed(now_s1, last_mode_q, debounce_q);
	assign save_ok  = save_p_s1 && sjlt_pkg::elapsed(now_s1, last_save_q, debounce_q);
	assign auto_nx  = auto_q ^ mode_tgl;

	// Light difference against tolerance
	assign diff     = $signed({1'b0, left_s1}) - $signed({1'b0, right_s1});
	assign mag      = diff[LIGHT_BITS] ? -diff : diff;
	assign light_go = CMP_W'(mag) >= CMP_W'(tol_q);

	// Position arithmetic
	assign pos_up9   = {1'b0, pos_q} + {5'b0, step_q};
	assign pos_dn9   = {1'b0, pos_q} - {5'b0, step_q};
	assign min_plus9 = {1'b0, pos_min_q} + {5'b0, step_q};

	// Joystick offset and thresholds
	assign joy_off = $signed({1'b0, joy_s1}) - $signed({1'b0, center_q});
	assign thr_pos = $signed({1'b0, thresh_q});
	assign thr_neg = -thr_pos;
	assign joy_up  = joy_off >= thr_pos;
	assign joy_dn  = joy_off <= thr_neg;
	assign move_ok = (joy_up || joy_dn) && sjlt_pkg::elapsed(now_s1, last_move_q, debounce_q);

	// Next position and move time
	always_comb begin
		pos_nx       = pos_q;
		last_move_nx = last_move_q;
		if (auto_nx) begin
			if (light_go) begin
				if (!diff[LIGHT_BITS] && (diff != '0)) begin
					if (pos_q > pos_min_q) begin
						pos_nx = pos_dn9[8] ? 8'd0 : pos_dn9[7:0];
					end
				end else begin
					if (pos_q < pos_max_q) begin
						pos_nx = pos_up9[8] ? 8'd255 : pos_up9[7:0];
					end
				end
			end
		end else begin
			// A second try in the same sample is never past debounce
			if (move_ok) begin
				last_move_nx = now_s1;
				if (joy_up) begin
					if (pos_up9 <= {1'b0, pos_max_q}) begin
						pos_nx = pos_up9[7:0];
					end
				end else begin
					if ({1'b0, pos_q} >= min_plus9) begin
						pos_nx = pos_dn9[7:0];
					end
				end
			end
			if (rec_p_s1) begin
				pos_nx = home_q;
			end
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			now_s1    <= in_ch.now_ms;
			joy_s1    <= in_ch.joystick_level;
			left_s1   <= in_ch.left_light;
			right_s1  <= in_ch.right_light;
			mode_p_s1 <= in_ch.mode_press;
			save_p_s1 <= in_ch.save_press;
			rec_p_s1  <= in_ch.recenter_press;
		end
	end

	// Tracker state: advance as each sample moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= sjlt_pkg::POSITION_RST;
			auto_q      <= 1'b0;
			last_move_q <= '0;
			last_mode_q <= '0;
			last_save_q <= '0;
		end else if (adv_out) begin
			pos_q       <= pos_nx;
			auto_q      <= auto_nx;
			last_move_q <= last_move_nx;
			if (mode_tgl) begin
				last_mode_q <= now_s1;
			end
			if (save_ok) begin
				last_save_q <= now_s1;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_pos_q  <= pos_nx;
			out_auto_q <= auto_nx;
			out_save_q <= save_ok;
		end
	end

	// Register writes
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q  <= sjlt_pkg::POS_MIN_RST;
			pos_max_q  <= sjlt_pkg::POS_MAX_RST;
			step_q     <= sjlt_pkg::STEP_RST;
			center_q   <= sjlt_pkg::CENTER_RST;
			thresh_q   <= sjlt_pkg::THRESH_RST;
			tol_q      <= sjlt_pkg::TOL_RST;
			debounce_q <= sjlt_pkg::DEBOUNCE_RST;
			home_q     <= sjlt_pkg::HOME_RST;
		end else if (cfg_wr) begin
			case (sjlt_pkg::reg_idx_t'(paddr[4:2]))
				sjlt_pkg::REG_POS_MIN:       pos_min_q  <= pwdata[7:0];
				sjlt_pkg::REG_POS_MAX:       pos_max_q  <= pwdata[7:0];
				sjlt_pkg::REG_STEP_SIZE:     step_q     <= pwdata[3:0];
				sjlt_pkg::REG_JOY_CENTER:    center_q   <= pwdata[7:0];
				sjlt_pkg::REG_JOY_THRESHOLD: thresh_q   <= pwdata[7:0];
				sjlt_pkg::REG_LIGHT_TOL:     tol_q      <= pwdata[sjlt_pkg::TOL_W-1:0];
				sjlt_pkg::REG_DEBOUNCE_MS:   debounce_q <= pwdata[15:0];
				sjlt_pkg::REG_HOME_POSITION: home_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (sjlt_pkg::reg_idx_t'(paddr[4:2]))
			sjlt_pkg::REG_POS_MIN:       prdata = {24'h0, pos_min_q};
			sjlt_pkg::REG_POS_MAX:       prdata = {24'h0, pos_max_q};
			sjlt_pkg::REG_STEP_SIZE:     prdata = {28'h0, step_q};
			sjlt_pkg::REG_JOY_CENTER:    prdata = {24'h0, center_q};
			sjlt_pkg::REG_JOY_THRESHOLD: prdata = {24'h0, thresh_q};
			sjlt_pkg::REG_LIGHT_TOL:     prdata = {22'h0, tol_q};
			sjlt_pkg::REG_DEBOUNCE_MS:   prdata = {16'h0, debounce_q};
			sjlt_pkg::REG_HOME_POSITION: prdata = {24'h0, home_q};
			default:                     prdata = '0;
		endcase
	end

	// Checks
	`SJLT_ASSERT_NOW(a_out_matches_state, out_valid_q,
		(out_pos_q == pos_q) && (out_auto_q == auto_q), "result differs from tracker state")
	`SJLT_ASSERT_NOW(a_no_overrun, valid_s1 && out_valid_q && !out_ch.ready,
		!in_ch.ready, "input stage would be overwritten")
	`SJLT_ASSERT_NEXT(a_recenter, adv_out && !auto_nx && rec_p_s1,
		pos_q == $past(home_q), "recenter did not set home position")
	`SJLT_ASSERT_NEXT(a_state_hold, !adv_out,
		$stable(pos_q) && $stable(last_move_q) && $stable(auto_q),
		"state changed without a sample")

endmodule

@@ tb/servo_joystick_light_tracker_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_joystick_light_tracker_unit_test
// Self-checking bench for the servo tracker. A shadow copy of the tracker
// state predicts every result. Directed samples cover debounce edges, both
// modes, recenter, saturation, inverted limits and timestamp wrap. Random
// phases follow under changing register settings, with bursts of source idle
// and sink stall.
// ----------------------------------------------------------------------------
module servo_joystick_light_tracker_unit_test;

	localparam int LIGHT_BITS   = 10;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct {
		logic [31:0]           now_ms;
		logic [7:0]            joystick_level;
		logic [LIGHT_BITS-1:0] left_light;
		logic [LIGHT_BITS-1:0] right_light;
		logic                  mode_press;
		logic                  save_press;
		logic                  recenter_press;
	} servo_sample_t;

	typedef struct {
		logic [7:0] servo_position;
		logic       auto_mode;
		logic       save_request;
	} servo_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [sjlt_pkg::ADDR_W-1:0]   paddr;
	logic [sjlt_pkg::DATA_W-1:0]   pwdata;
	logic [sjlt_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	sjlt_in_if #(.LIGHT_BITS(LIGHT_BITS)) in_ch ();
	sjlt_out_if                            out_ch ();

	servo_joystick_light_tracker_unit #(.LIGHT_BITS(LIGHT_BITS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow registers and tracker state
	logic [7:0]                  cfg_pos_min;
	logic [7:0]                  cfg_pos_max;
	logic [3:0]                  cfg_step;
	logic [7:0]                  cfg_center;
	logic [7:0]                  cfg_threshold;
	logic [sjlt_pkg::TOL_W-1:0]  cfg_tolerance;
	logic [15:0]                 cfg_debounce;
	logic [7:0]                  cfg_home;
	logic [7:0]                  trk_position;
	logic                        trk_auto;
	logic [31:0]                 last_move_ms;
	logic [31:0]                 last_mode_ms;
	logic [31:0]                 last_save_ms;

	servo_result_t predicted_servo[$];
	logic [31:0]   clock_ms;
	int            errors = 0;
	int            cycles = 0;
	int            idle_pct;
	int            stall_pct;
	int            stall_cycles = 0;
	bit            quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// True when more than the debounce time has passed, modulo 2^32
	function automatic bit debounce_expired(logic [31:0] now, logic [31:0] last);
		logic [31:0] delta;
		delta = now - last;
		return delta > {16'h0000, cfg_debounce};
	endfunction

	// Advance the shadow tracker by one sample and return its result
	function automatic servo_result_t track_sample(servo_sample_t s);
		servo_result_t r;
		int pos, stp, diff, mag, off, thr;
		pos = int'(trk_position);
		stp = int'(cfg_step);
		r.save_request = 1'b0;
		if (s.mode_press && debounce_expired(s.now_ms, last_mode_ms)) begin
			trk_auto = !trk_auto;
			last_mode_ms = s.now_ms;
		end
		if (s.save_press && debounce_expired(s.now_ms, last_save_ms)) begin
			r.save_request = 1'b1;
			last_save_ms = s.now_ms;
		end
		if (trk_auto) begin
			// step toward the brighter side while strictly inside the limits
			diff = int'(s.left_light) - int'(s.right_light);
			mag = diff < 0 ? -diff : diff;
			if (mag >= int'(cfg_tolerance)) begin
				if (diff > 0) begin
					if (pos > int'(cfg_pos_min)) pos = (pos - stp < 0) ? 0 : pos - stp;
				end else if (pos < int'(cfg_pos_max)) begin
					pos = (pos + stp > 255) ? 255 : pos + stp;
				end
			end
		end else begin
			// rate-limited joystick moves; the timestamp advances even when blocked
			off = int'(s.joystick_level) - int'(cfg_center);
			thr = int'(cfg_threshold);
			if (off >= thr && debounce_expired(s.now_ms, last_move_ms)) begin
				if (pos + stp <= int'(cfg_pos_max)) pos = pos + stp;
				last_move_ms = s.now_ms;
			end
			if (off <= -thr && debounce_expired(s.now_ms, last_move_ms)) begin
				if (pos - stp >= int'(cfg_pos_min)) pos = pos - stp;
				last_move_ms = s.now_ms;
			end
			if (s.recenter_press) pos = int'(cfg_home);
		end
		trk_position = pos[7:0];
		r.servo_position = trk_position;
		r.auto_mode = trk_auto;
		return r;
	endfunction

	function automatic servo_sample_t make_sample(logic [31:0] now, logic [7:0] joy,
			logic [LIGHT_BITS-1:0] left, logic [LIGHT_BITS-1:0] right,
			logic mode_p, logic save_p, logic rec_p);
		servo_sample_t s;
		s.now_ms = now;
		s.joystick_level = joy;
		s.left_light = left;
		s.right_light = right;
		s.mode_press = mode_p;
		s.save_press = save_p;
		s.recenter_press = rec_p;
		clock_ms = now;
		return s;
	endfunction

	// Random sample biased toward debounce edges, threshold edges and tolerance edges
	function automatic servo_sample_t random_sample();
		servo_sample_t s;
		int lvl, tol, other;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(0, 40);
			4, 5:       clock_ms = clock_ms + cfg_debounce + $urandom_range(0, 2);
			6, 7:       clock_ms = clock_ms + $urandom_range(0, 2 * cfg_debounce + 2);
			8:          clock_ms = clock_ms + $urandom_range(0, 100000);
			default:    clock_ms = $urandom();
		endcase
		s.now_ms = clock_ms;
		case ($urandom_range(0, 4))
			0:       lvl = int'(cfg_center) + int'(cfg_threshold) - int'($urandom_range(0, 1));
			1:       lvl = int'(cfg_center) - int'(cfg_threshold) + int'($urandom_range(0, 1));
			2:       lvl = $urandom_range(0, 1) ? 255 : 0;
			default: lvl = int'($urandom_range(0, 255));
		endcase
		if (lvl < 0) lvl = 0;
		else if (lvl > 255) lvl = 255;
		s.joystick_level = lvl[7:0];
		s.left_light = LIGHT_BITS'($urandom_range(0, 1023));
		s.right_light = LIGHT_BITS'($urandom_range(0, 1023));
		if ($urandom_range(0, 2) == 0) begin
			tol = int'(cfg_tolerance) - int'($urandom_range(0, 1));
			other = int'(s.left_light) + ($urandom_range(0, 1) ? tol : -tol);
			s.right_light = (other < 0 || other > 1023) ? s.left_light : other[LIGHT_BITS-1:0];
		end
		s.mode_press = $urandom_range(0, 5) == 0;
		s.save_press = $urandom_range(0, 3) == 0;
		s.recenter_press = $urandom_range(0, 9) == 0;
		return s;
	endfunction

	// Present one request, predict it at acceptance, then maybe idle
	task automatic send_sample(servo_sample_t s);
		in_ch.valid <= 1'b1;
		in_ch.now_ms <= s.now_ms;
		in_ch.joystick_level <= s.joystick_level;
		in_ch.left_light <= s.left_light;
		in_ch.right_light <= s.right_light;
		in_ch.mode_press <= s.mode_press;
		in_ch.save_press <= s.save_press;
		in_ch.recenter_press <= s.recenter_press;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predicted_servo.push_back(track_sample(s));
		if (!quiet && int'($urandom_range(0, 99)) < idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Hold the source until every predicted result has come back
	task automatic wait_results_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (predicted_servo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, access phase, then idle with psel low
	task automatic write_register(sjlt_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sjlt_pkg::REG_POS_MIN:       cfg_pos_min = value[7:0];
			sjlt_pkg::REG_POS_MAX:       cfg_pos_max = value[7:0];
			sjlt_pkg::REG_STEP_SIZE:     cfg_step = value[3:0];
			sjlt_pkg::REG_JOY_CENTER:    cfg_center = value[7:0];
			sjlt_pkg::REG_JOY_THRESHOLD: cfg_threshold = value[7:0];
			sjlt_pkg::REG_LIGHT_TOL:     cfg_tolerance = value[sjlt_pkg::TOL_W-1:0];
			sjlt_pkg::REG_DEBOUNCE_MS:   cfg_debounce = value[15:0];
			sjlt_pkg::REG_HOME_POSITION: cfg_home = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all_registers(logic [7:0] lo, logic [7:0] hi, logic [3:0] stp,
			logic [7:0] center, logic [7:0] thr, logic [sjlt_pkg::TOL_W-1:0] tol,
			logic [15:0] db, logic [7:0] home);
		write_register(sjlt_pkg::REG_POS_MIN, 32'(lo));
		write_register(sjlt_pkg::REG_POS_MAX, 32'(hi));
		write_register(sjlt_pkg::REG_STEP_SIZE, 32'(stp));
		write_register(sjlt_pkg::REG_JOY_CENTER, 32'(center));
		write_register(sjlt_pkg::REG_JOY_THRESHOLD, 32'(thr));
		write_register(sjlt_pkg::REG_LIGHT_TOL, 32'(tol));
		write_register(sjlt_pkg::REG_DEBOUNCE_MS, 32'(db));
		write_register(sjlt_pkg::REG_HOME_POSITION, 32'(home));
	endtask

	task automatic send_random_samples(int count);
		repeat (count) send_sample(random_sample());
	endtask

	// Joystick moves, debounce edges, recenter and save under reset settings
	task automatic test_manual_moves();
		send_sample(make_sample(32'd0, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd301, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd601, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd602, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd602, 8'd247, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b1));
		send_sample(make_sample(32'd1000, 8'd8, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd1000, 8'd0, 10'd0, 10'd0, 1'b0, 1'b1, 1'b0));
		send_sample(make_sample(32'd1200, 8'd128, 10'd0, 10'd0, 1'b0, 1'b1, 1'b0));
	endtask

	// Mode toggle, light tracking both ways, tolerance edge, debounced toggle back
	task automatic test_auto_tracking();
		send_sample(make_sample(32'd2000, 8'd128, 10'd0, 10'd0, 1'b1, 1'b0, 1'b0));
		send_sample(make_sample(32'd2001, 8'd128, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd2002, 8'd128, 10'd0, 10'd1023, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd2003, 8'd128, 10'd100, 10'd50, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd2004, 8'd128, 10'd50, 10'd99, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd2100, 8'd0, 10'd0, 10'd0, 1'b1, 1'b0, 1'b0));
		send_sample(make_sample(32'd2400, 8'd255, 10'd0, 10'd0, 1'b1, 1'b0, 1'b0));
	endtask

	// Inverted limits, zero threshold, zero tolerance, saturation, timestamp wrap
	task automatic test_special_cases();
		wait_results_drained();
		write_all_registers(8'd200, 8'd50, 4'd15, 8'd128, 8'd0, 10'd0, 16'd0, 8'd250);
		send_sample(make_sample(32'd3000, 8'd128, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd3001, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd3002, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1));
		send_sample(make_sample(32'd3003, 8'd128, 10'd512, 10'd512, 1'b1, 1'b0, 1'b0));
		wait_results_drained();
		write_register(sjlt_pkg::REG_POS_MIN, 32'd0);
		write_register(sjlt_pkg::REG_POS_MAX, 32'd255);
		send_sample(make_sample(32'd3004, 8'd128, 10'd512, 10'd512, 1'b0, 1'b0, 1'b0));
		send_sample(make_sample(32'd3005, 8'd128, 10'd700, 10'd0, 1'b0, 1'b0, 1'b0));
		wait_results_drained();
		write_register(sjlt_pkg::REG_HOME_POSITION, 32'd5);
		send_sample(make_sample(32'd3006, 8'd128, 10'd0, 10'd0, 1'b1, 1'b0, 1'b1));
		send_sample(make_sample(32'd3007, 8'd128, 10'd900, 10'd3, 1'b1, 1'b0, 1'b0));
		wait_results_drained();
		write_register(sjlt_pkg::REG_DEBOUNCE_MS, 32'd16);
		send_sample(make_sample(32'hFFFF_FFF0, 8'd128, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0));
		send_sample(make_sample(32'h0000_0010, 8'd255, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0));
		send_sample(make_sample(32'h0000_0018, 8'd0, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0));
	endtask

	// Random samples under both extreme register settings
	task automatic test_extreme_configs();
		wait_results_drained();
		write_all_registers(8'd0, 8'd255, 4'd15, 8'd0, 8'd255, 10'd1023, 16'hFFFF, 8'd255);
		send_random_samples(40);
		wait_results_drained();
		write_all_registers(8'd255, 8'd0, 4'd1, 8'd255, 8'd1, 10'd0, 16'd0, 8'd0);
		send_random_samples(40);
	endtask

	// Random settings per phase with changing idle and stall rates
	task automatic test_random_phases();
		logic [7:0] lo, hi, center, thr, home;
		logic [3:0] stp;
		logic [sjlt_pkg::TOL_W-1:0] tol;
		logic [15:0] db;
		repeat (7) begin
			wait_results_drained();
			if ($urandom_range(0, 7) == 0) begin
				lo = 8'($urandom_range(0, 255));
				hi = 8'($urandom_range(0, 255));
			end else begin
				lo = 8'($urandom_range(0, 230));
				hi = 8'($urandom_range(32'(lo), 255));
			end
			case ($urandom_range(0, 5))
				0:       db = 16'd0;
				1:       db = 16'hFFFF;
				default: db = 16'($urandom_range(1, 600));
			endcase
			stp = 4'($urandom_range(1, 15));
			center = 8'($urandom_range(0, 255));
			thr = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 100));
			tol = (sjlt_pkg::TOL_W)'(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 1023) : $urandom_range(0, 100));
			home = 8'($urandom_range(0, 255));
			write_all_registers(lo, hi, stp, center, thr, tol, db, home);
			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 10;
				default: idle_pct = 35;
			endcase
			stall_pct = $urandom_range(0, 2) * 15;
			send_random_samples(80);
		end
	endtask

	// Full-rate traffic with no idle and no stall
	task automatic test_back_to_back();
		wait_results_drained();
		write_all_registers(sjlt_pkg::POS_MIN_RST, sjlt_pkg::POS_MAX_RST, sjlt_pkg::STEP_RST,
			sjlt_pkg::CENTER_RST, sjlt_pkg::THRESH_RST, sjlt_pkg::TOL_RST, 16'd20,
			sjlt_pkg::HOME_RST);
		quiet = 1'b1;
		send_random_samples(110);
	endtask

	// Sink stalls in random bursts
	always @(posedge clk) begin : result_ready
		if (stall_cycles == 0 && !quiet && int'($urandom_range(0, 99)) < stall_pct)
			stall_cycles = $urandom_range(1, 19);
		if (stall_cycles > 0) begin
			out_ch.ready <= 1'b0;
			stall_cycles--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		servo_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (predicted_servo.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending: expected none, actual pos=%0d",
					$time, out_ch.servo_position);
			end else begin
				want = predicted_servo.pop_front();
				compare_field("servo_position", want.servo_position, out_ch.servo_position);
				compare_field("auto_mode", {7'd0, want.auto_mode}, {7'd0, out_ch.auto_mode});
				compare_field("save_request", {7'd0, want.save_request},
					{7'd0, out_ch.save_request});
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("servo_joystick_light_tracker_unit_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.now_ms = '0;
		in_ch.joystick_level = '0;
		in_ch.left_light = '0;
		in_ch.right_light = '0;
		in_ch.mode_press = 1'b0;
		in_ch.save_press = 1'b0;
		in_ch.recenter_press = 1'b0;
		cfg_pos_min = sjlt_pkg::POS_MIN_RST;
		cfg_pos_max = sjlt_pkg::POS_MAX_RST;
		cfg_step = sjlt_pkg::STEP_RST;
		cfg_center = sjlt_pkg::CENTER_RST;
		cfg_threshold = sjlt_pkg::THRESH_RST;
		cfg_tolerance = sjlt_pkg::TOL_RST;
		cfg_debounce = sjlt_pkg::DEBOUNCE_RST;
		cfg_home = sjlt_pkg::HOME_RST;
		trk_position = sjlt_pkg::POSITION_RST;
		trk_auto = 1'b0;
		last_move_ms = '0;
		last_mode_ms = '0;
		last_save_ms = '0;
		clock_ms = '0;
		idle_pct = 20;
		stall_pct = 20;
		quiet = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_manual_moves();
		test_auto_tracking();
		test_special_cases();
		test_extreme_configs();
		test_random_phases();
		test_back_to_back();
		wait_results_drained();

		if (errors == 0 && predicted_servo.size() == 0) begin
			$display("servo_joystick_light_tracker_unit_test: PASS");
		end else begin
			$display("servo_joystick_light_tracker_unit_test: FAIL");
		end
		$finish;
	end

endmodule
